// File: hdl/mrt_pkg.sv
// constants and types shared by the marked run tracker
// no dependencies

package mrt_pkg;

   localparam int MAX_POSITIONS = 1024;
   localparam int ADDR_W        = $clog2(MAX_POSITIONS);
   localparam int POS_W         = 11;
   localparam int STATUS_W      = 2;
   localparam logic [POS_W-1:0] POSITIONS_RESET = POS_W'(1024);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ALREADY = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

endpackage

// File: hdl/marked_run_tracker_unit.sv
// Marked run tracker: marks one-based slots and answers the run of marked slots holding each.
// Uses mrt_pkg for sizes and status codes.
// Every accepted request is first read, taking the neighbour marks and run ends from synchronous
// memory; then, once no stalled response is waiting, the run is worked out, its two ends written
// back and the response register loaded. A finished response may wait on rsp_stall while the next
// request is read. After reset the mark memory is swept to zero over all MAX_POSITIONS (1024)
// slots; no request is taken during that sweep, while csr writes are taken at any time. Run ends
// are stored twice: the first slot of a run keeps its last slot and the last slot keeps its first,
// so a merge needs one read and one write per run-end memory.

module marked_run_tracker_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [mrt_pkg::POS_W-1:0]    csr_wdata,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mrt_pkg::POS_W-1:0]    req_position,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mrt_pkg::POS_W-1:0]    rsp_run_first,
   output logic [mrt_pkg::POS_W-1:0]    rsp_run_last,
   output logic [mrt_pkg::STATUS_W-1:0] rsp_status
);
   import mrt_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // memories
   logic              mark_a_mem [MAX_POSITIONS];
   logic              mark_b_mem [MAX_POSITIONS];
   logic [ADDR_W-1:0] first_to_last_mem [MAX_POSITIONS];
   logic [ADDR_W-1:0] last_to_first_mem [MAX_POSITIONS];

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic [POS_W-1:0]  limit_ff, limit_in;

   // request held for the execute cycle
   logic [POS_W-1:0]  pos_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic              range_err_ff, has_left_ff, has_right_ff;

   // registered memory reads
   logic              mk_left_ff, mk_self_ff, mk_right_ff;
   logic [ADDR_W-1:0] far_first_ff, far_last_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_first_ff, rsp_last_ff;
   status_type        rsp_status_ff;

   logic              req_take, exec_go, do_write;
   logic [31:0]       limit_eff;
   logic              range_err;
   logic [ADDR_W-1:0] idx, idx_left, idx_right;
   logic              has_left, has_right;
   logic [ADDR_W-1:0] run_first, run_last;
   logic              mark_we, mark_wdata;
   logic [ADDR_W-1:0] mark_waddr;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign do_write  = exec_go && !range_err_ff && !mk_self_ff;

   // range check and neighbour addresses
   always_comb begin
      limit_eff = (32'(limit_ff) > 32'(MAX_POSITIONS)) ? 32'(MAX_POSITIONS) : 32'(limit_ff);
      range_err = (req_position == '0) || (32'(req_position) > limit_eff);
      idx       = ADDR_W'(32'(req_position) - 32'd1);
      has_left  = (idx != '0);
      has_right = (32'(idx) != 32'(MAX_POSITIONS - 1));
      idx_left  = has_left  ? ADDR_W'(32'(idx) - 32'd1) : idx;
      idx_right = has_right ? ADDR_W'(32'(idx) + 32'd1) : idx;
   end

   // join with the runs on either side
   always_comb begin
      run_first = (has_left_ff && mk_left_ff)   ? far_first_ff : idx_ff;
      run_last  = (has_right_ff && mk_right_ff) ? far_last_ff  : idx_ff;
   end

   assign mark_we    = (state_ff == ST_CLEAR) || do_write;
   assign mark_waddr = (state_ff == ST_CLEAR) ? clear_addr_ff : idx_ff;
   assign mark_wdata = (state_ff != ST_CLEAR);

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_a_mem[mark_waddr] <= mark_wdata;
      end
      if (req_take) begin
         mk_left_ff <= mark_a_mem[idx_left];
         mk_self_ff <= mark_a_mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_b_mem[mark_waddr] <= mark_wdata;
      end
      if (req_take) begin
         mk_right_ff <= mark_b_mem[idx_right];
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         first_to_last_mem[run_first] <= run_last;
      end
      if (req_take) begin
         far_last_ff <= first_to_last_mem[idx_right];
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         last_to_first_mem[run_last] <= run_first;
      end
      if (req_take) begin
         far_first_ff <= last_to_first_mem[idx_left];
      end
   end

   // control next state
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      limit_in      = csr_we ? csr_wdata : limit_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = ADDR_W'(32'(clear_addr_ff) + 32'd1);
            if (32'(clear_addr_ff) == 32'(MAX_POSITIONS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         limit_ff      <= POSITIONS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         limit_ff      <= limit_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (exec_go) begin
            if (range_err_ff) begin
               rsp_first_ff  <= pos_ff;
               rsp_last_ff   <= pos_ff;
               rsp_status_ff <= STATUS_RANGE;
            end else if (mk_self_ff) begin
               rsp_first_ff  <= pos_ff;
               rsp_last_ff   <= pos_ff;
               rsp_status_ff <= STATUS_ALREADY;
            end else begin
               rsp_first_ff  <= POS_W'(32'(run_first) + 32'd1);
               rsp_last_ff   <= POS_W'(32'(run_last) + 32'd1);
               rsp_status_ff <= STATUS_OK;
            end
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         pos_ff       <= req_position;
         idx_ff       <= idx;
         range_err_ff <= range_err;
         has_left_ff  <= has_left;
         has_right_ff <= has_right;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_run_first = rsp_first_ff;
   assign rsp_run_last  = rsp_last_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// File: sim/tb.sv
// self-checking testbench for marked_run_tracker_unit: random and directed marks checked
// against an in-bench run predictor, with idling on both channels
// depends on mrt_pkg and the unit itself

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mrt_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [POS_W-1:0] first;
      logic [POS_W-1:0] last;
      status_type       status;
   } run_answer_type;

   typedef struct {
      logic [POS_W-1:0] position;
      int unsigned      gap;
   } mark_request_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [POS_W-1:0]    csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [POS_W-1:0]    req_position = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [POS_W-1:0]    rsp_run_first;
   logic [POS_W-1:0]    rsp_run_last;
   logic [STATUS_W-1:0] rsp_status;

   // run predictor state
   bit               slot_marked [MAX_POSITIONS];
   int unsigned      run_partner [MAX_POSITIONS];
   logic [POS_W-1:0] slots_limit = POSITIONS_RESET;
   run_answer_type   expected_runs [$];

   // request generation
   mark_request_type pending [$];
   bit          planned [MAX_POSITIONS];
   int unsigned planned_list [$];
   int unsigned req_gap_max = 6;
   int unsigned rsp_gap_max = 6;
   int unsigned stall_left = 0;
   int unsigned issued = 0;
   int unsigned answered = 0;
   int unsigned failures = 0;
   int unsigned settings_used = 0;
   int unsigned status_count [3];
   int unsigned cycles = 0;

   marked_run_tracker_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_run_first (rsp_run_first),
      .rsp_run_last  (rsp_run_last),
      .rsp_status    (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void mark_slot(input logic [POS_W-1:0] pos);
      int unsigned    lim, p, lo, hi;
      run_answer_type ans;
      lim = (slots_limit > MAX_POSITIONS) ? MAX_POSITIONS : slots_limit;
      ans.first = pos;
      ans.last = pos;
      if (pos == 0 || pos > lim) begin
         ans.status = STATUS_RANGE;
      end else if (slot_marked[pos - 1]) begin
         ans.status = STATUS_ALREADY;
      end else begin
         p = pos - 1;
         slot_marked[p] = 1'b1;
         lo = p;
         hi = p;
         // neighbours are looked at across the whole row, not just up to the limit
         if (p > 0 && slot_marked[p - 1]) lo = run_partner[p - 1];
         if (p + 1 < MAX_POSITIONS && slot_marked[p + 1]) hi = run_partner[p + 1];
         run_partner[lo] = hi;
         run_partner[hi] = lo;
         ans.first = POS_W'(lo + 1);
         ans.last = POS_W'(hi + 1);
         ans.status = STATUS_OK;
      end
      expected_runs.push_back(ans);
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int unsigned lim, roll, cand, tries;
      lim = (slots_limit > MAX_POSITIONS) ? MAX_POSITIONS : slots_limit;
      roll = $urandom_range(0, 99);
      if (roll < 65 && lim > 0) begin
         // mostly grow or join existing runs
         for (tries = 0; tries < 8; tries++) begin
            if (planned_list.size() > 0 && $urandom_range(0, 3) != 0) begin
               cand = planned_list[$urandom_range(0, planned_list.size() - 1)];
               cand = $urandom_range(0, 1) ? cand + 1 : cand - 1;
            end else begin
               cand = $urandom_range(1, lim);
            end
            if (cand >= 1 && cand <= lim && !planned[cand - 1]) return POS_W'(cand);
         end
      end
      if (roll < 80 && lim > 0) return POS_W'($urandom_range(1, lim));
      if (roll < 94) return ($urandom_range(0, 4) == 0) ? '0 : POS_W'($urandom_range(lim + 1, 2047));
      return POS_W'($urandom_range(0, 2047));
   endfunction

   task automatic send(input logic [POS_W-1:0] pos);
      mark_request_type r;
      int unsigned      lim;
      lim = (slots_limit > MAX_POSITIONS) ? MAX_POSITIONS : slots_limit;
      if (pos != 0 && pos <= lim && !planned[pos - 1]) begin
         planned[pos - 1] = 1'b1;
         planned_list.push_back(pos);
      end
      r.position = pos;
      r.gap = $urandom_range(0, req_gap_max);
      pending.push_back(r);
      issued++;
   endtask

   task automatic settle();
      while (answered < issued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [POS_W-1:0] value);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      slots_limit = value;
      settings_used++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) mark_slot(req_position);
         if (!req_valid || !req_stall) begin
            if (pending.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending[0].gap > 0) begin
               pending[0].gap = pending[0].gap - 1;
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_position <= pending[0].position;
               void'(pending.pop_front());
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : watch_responses
      run_answer_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_runs.size() == 0) begin
               $error("unexpected response: run_first %0d run_last %0d status %0d",
                      rsp_run_first, rsp_run_last, rsp_status);
               failures++;
            end else begin
               want = expected_runs.pop_front();
               if (rsp_run_first !== want.first) begin
                  $error("run_first: expected %0d, got %0d", want.first, rsp_run_first);
                  failures++;
               end
               if (rsp_run_last !== want.last) begin
                  $error("run_last: expected %0d, got %0d", want.last, rsp_run_last);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  failures++;
               end
               status_count[want.status]++;
            end
            answered++;
            stall_left = $urandom_range(0, rsp_gap_max);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("marked_run_tracker_unit test failed");
         $finish;
      end
   end

   initial begin
      logic [POS_W-1:0] phase_limits [6];
      int unsigned      ph, k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // row size still at its reset value
      send(11'd1025);
      send(11'd0);
      write_limit(11'd1);
      send(11'd1);
      send(11'd1);
      send(11'd2);
      send(11'd2047);
      // empty row: even a marked slot is out of range
      write_limit(11'd0);
      send(11'd1);
      // oversized register saturates to the full row
      write_limit(11'd2047);
      send(11'd1024);
      send(11'd1023);
      send(11'd1025);
      send(11'd3);
      send(11'd5);
      send(11'd4);
      send(11'd2);
      send(11'd2);
      write_limit(11'd10);
      send(11'd8);
      send(11'd10);
      send(11'd9);
      // lowered row size, runs still reach past it
      write_limit(11'd7);
      send(11'd7);
      send(11'd6);

      phase_limits = '{11'd1024, 11'd40, 11'd2047, POS_W'($urandom_range(100, 1022)),
                       11'd1023, 11'd600};
      for (ph = 0; ph < 6; ph++) begin
         unique case (ph % 3)
            0: begin
               req_gap_max = 6;
               rsp_gap_max = 6;
            end
            1: begin
               req_gap_max = 0;
               rsp_gap_max = 0;
            end
            default: begin
               req_gap_max = 0;
               rsp_gap_max = 6;
            end
         endcase
         write_limit(phase_limits[ph]);
         for (k = 0; k < 105; k++) send(pick_position());
      end

      settle();
      repeat (8) @(posedge clock);
      $display("%0d requests over %0d row sizes: %0d marked, %0d repeats, %0d out of range",
               issued, settings_used, status_count[STATUS_OK], status_count[STATUS_ALREADY],
               status_count[STATUS_RANGE]);
      if (failures == 0 && expected_runs.size() == 0) begin
         $display("marked_run_tracker_unit test passed");
      end else begin
         $display("marked_run_tracker_unit test failed");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/mrt_pkg.sv
hdl/marked_run_tracker_unit.sv
sim/tb.sv
